[rtl/crta_pkg.sv]
// Shared constants, register indexes and control types of the per-class traffic rate averager.
// No dependencies; every other file refers to this package by scoped names.
package crta_pkg;

   localparam int NUM_CLASSES_DEF = 4;
   localparam int WINDOW_MAX_DEF  = 16;

   localparam int CLASS_W   = 2;
   localparam int COUNT_W   = 32;
   localparam int DELTA_W   = 32;
   localparam int RATE_W    = 32;
   localparam int SUM_W     = 36;
   localparam int WLEN_W    = 5;
   localparam int SCALE_W   = 24;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = SUM_W + SCALE_W;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_SCALE    = CSR_INDEX_W'(1);

   localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST = WLEN_W'(4);
   localparam logic [SCALE_W-1:0] RATE_SCALE_RST    = SCALE_W'(16384);

   // sequencer status towards the datapath
   typedef struct packed {
      logic busy;       // clear or re-sum pass running, no input transfer
      logic clear;      // ring being zeroed
      logic resum_rd;   // ring read issued for a re-sum
      logic acc_valid;  // ring read data of a re-sum is due this cycle
   } sweep_ctl_type;

endpackage

[rtl/crta_ring.sv]
// Delta ring storage: one write port, one read port with registered read data.
// Depends on crta_pkg for the delta width.
module crta_ring #(
   parameter int NUM_CLASSES = crta_pkg::NUM_CLASSES_DEF,
   parameter int WINDOW_MAX  = crta_pkg::WINDOW_MAX_DEF,
   localparam int CW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
   localparam int PW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int AW         = CW + PW
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [crta_pkg::DELTA_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [crta_pkg::DELTA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << AW;

   logic [crta_pkg::DELTA_W-1:0] mem [DEPTH];
   logic [crta_pkg::DELTA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/crta_sweep.sv]
// Sequencer for the ring clearing pass after reset and the re-sum pass after a window change.
// Depends on crta_pkg for the control struct.
module crta_sweep #(
   parameter int NUM_CLASSES = crta_pkg::NUM_CLASSES_DEF,
   parameter int WINDOW_MAX  = crta_pkg::WINDOW_MAX_DEF,
   localparam int CW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
   localparam int PW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int AW         = CW + PW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    win_write,
   output crta_pkg::sweep_ctl_type ctl,
   output logic [AW-1:0]           sweep_index,
   output logic [AW-1:0]           acc_index
);

   localparam int SWEEP_LEN = NUM_CLASSES << PW;
   localparam logic [AW-1:0] LAST = AW'(SWEEP_LEN - 1);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_RESUM = 2'd2;

   logic [1:0]    mode_ff, mode_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          acc_valid_ff, acc_valid_in;
   logic [AW-1:0] acc_index_ff;

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      unique case (mode_ff)
         MODE_CLEAR: begin
            // a window change needs no re-sum: the whole ring is zero
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST) begin
               mode_in = MODE_IDLE;
               cnt_in  = '0;
            end
         end
         MODE_RESUM: begin
            if (win_write) begin
               cnt_in = '0;
            end else if (cnt_ff == LAST) begin
               mode_in = MODE_IDLE;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         MODE_IDLE: begin
            if (win_write) begin
               mode_in = MODE_RESUM;
               cnt_in  = '0;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            cnt_in  = '0;
         end
      endcase
   end

   assign acc_valid_in = (mode_ff == MODE_RESUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CLEAR;
         cnt_ff       <= '0;
         acc_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_index_ff <= cnt_ff;
   end

   always_comb begin
      ctl.busy      = (mode_ff != MODE_IDLE);
      ctl.clear     = (mode_ff == MODE_CLEAR);
      ctl.resum_rd  = (mode_ff == MODE_RESUM);
      ctl.acc_valid = acc_valid_ff;
   end

   assign sweep_index = cnt_ff;
   assign acc_index   = acc_index_ff;

   a_clear_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CLEAR && cnt_ff == LAST) |=> (mode_ff == MODE_IDLE))
      else $error("clearing pass did not end in idle");

   a_resum_starts_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(mode_ff == MODE_RESUM) |-> (cnt_ff == '0 && $past(win_write)))
      else $error("re-sum pass entered without window write or at non-zero index");

endmodule

[rtl/crta_scale.sv]
// Scaling stage and result register: sum times rate scale, Q8.16 shift, 32-bit saturation.
// Depends on crta_pkg for field widths.
module crta_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [crta_pkg::CLASS_W-1:0] in_echo,
   input  logic [crta_pkg::DELTA_W-1:0] in_delta,
   input  logic [crta_pkg::SUM_W-1:0]   in_sum,
   input  logic [crta_pkg::SCALE_W-1:0] rate_scale,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [crta_pkg::CLASS_W-1:0] rsp_class_echo,
   output logic [crta_pkg::DELTA_W-1:0] rsp_new_delta,
   output logic [crta_pkg::RATE_W-1:0]  rsp_average_rate
);

   localparam int SAT_LSB = crta_pkg::FRAC_BITS + crta_pkg::RATE_W;

   logic                         s2_valid_ff, s2_valid_in;
   logic [crta_pkg::CLASS_W-1:0] s2_echo_ff;
   logic [crta_pkg::DELTA_W-1:0] s2_delta_ff;
   logic [crta_pkg::SUM_W-1:0]   s2_sum_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [crta_pkg::CLASS_W-1:0] out_echo_ff;
   logic [crta_pkg::DELTA_W-1:0] out_delta_ff;
   logic [crta_pkg::RATE_W-1:0]  out_rate_ff, out_rate_in;

   logic                         out_load;
   logic [crta_pkg::PROD_W-1:0]  product;

   assign out_load     = !out_valid_ff || rsp_ready;
   assign in_ready     = !s2_valid_ff || out_load;
   assign s2_valid_in  = in_ready ? in_valid : s2_valid_ff;
   assign out_valid_in = out_load ? s2_valid_ff : out_valid_ff;

   always_comb begin
      product = s2_sum_ff * rate_scale;
      if (|product[crta_pkg::PROD_W-1:SAT_LSB]) begin
         out_rate_in = '1;
      end else begin
         out_rate_in = product[SAT_LSB-1:crta_pkg::FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_echo_ff  <= in_echo;
         s2_delta_ff <= in_delta;
         s2_sum_ff   <= in_sum;
      end
      if (out_load && s2_valid_ff) begin
         out_echo_ff  <= s2_echo_ff;
         out_delta_ff <= s2_delta_ff;
         out_rate_ff  <= out_rate_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_class_echo   = out_echo_ff;
   assign rsp_new_delta    = out_delta_ff;
   assign rsp_average_rate = out_rate_ff;

endmodule

[rtl/per_class_traffic_rate_averager.sv]
// Per-class traffic rate averager.
// Request channel (req_*): a traffic class and its cumulative count, valid/ready.
// Response channel (rsp_*): class echo, delta since the class's last count (mod 2^32) and
// the windowed rate, (sum of the last window_length deltas * rate_scale) >> 16, saturated.
// Configuration (csr_*): write enable, register index, data; index 0 window_length
// (clamped to 1..WINDOW_MAX), index 1 rate_scale. The user must write them only while no
// transfer is in flight; the block does not enforce it. A request passes the input,
// scaling and result registers before its response is valid. Throughput: one transfer
// per cycle while no pass runs and the receiver keeps up, set by the single-ported delta
// ring read for the oldest delta and the running-sum update per class. Reset: all counts,
// sums and ring positions cleared at once; the delta ring is then zeroed by a clearing
// pass over its NUM_CLASSES * 2^ceil(log2(WINDOW_MAX)) entries (64 by default), req_ready
// low meanwhile. A window_length write outside that pass starts a re-sum pass over the
// same entries, req_ready low meanwhile; its last ring read is summed in the cycle after.
// A stalled receiver holds the result register; the scaling register and input register
// keep filling, then req_ready drops; nothing is lost or repeated.
// Depends on crta_pkg, crta_ring, crta_sweep and crta_scale.
module per_class_traffic_rate_averager #(
   parameter int NUM_CLASSES = crta_pkg::NUM_CLASSES_DEF,
   parameter int WINDOW_MAX  = crta_pkg::WINDOW_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [crta_pkg::CLASS_W-1:0]     req_traffic_class,
   input  logic [crta_pkg::COUNT_W-1:0]     req_cumulative_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [crta_pkg::CLASS_W-1:0]     rsp_class_echo,
   output logic [crta_pkg::DELTA_W-1:0]     rsp_new_delta,
   output logic [crta_pkg::RATE_W-1:0]      rsp_average_rate,
   input  logic                             csr_write,
   input  logic [crta_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crta_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LW = PW + 1;
   localparam int AW = CW + PW;
   localparam logic [LW-1:0] WMAX_L = LW'(WINDOW_MAX);
   localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_MAX - 1);

   // slot steps entries back from pos, steps in 1..WINDOW_MAX
   function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] pos,
                                               input logic [LW-1:0] steps);
      logic [LW-1:0] t;
      t = {1'b0, pos} + WMAX_L - steps;
      if (t >= WMAX_L) begin
         t = t - WMAX_L;
      end
      return t[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] pos);
      return (pos == POS_LAST) ? '0 : pos + PW'(1);
   endfunction

   function automatic logic [CW-1:0] class_fold(input logic [crta_pkg::CLASS_W-1:0] tc);
      if (int'(tc) >= NUM_CLASSES) begin
         return CW'(int'(tc) - NUM_CLASSES);
      end
      return CW'(tc);
   endfunction

   // configuration
   logic [crta_pkg::WLEN_W-1:0]  window_length_ff, window_length_in;
   logic [crta_pkg::SCALE_W-1:0] rate_scale_ff, rate_scale_in;
   logic                         win_write;
   logic [LW-1:0]                len_eff;

   assign win_write = csr_write && (csr_index == crta_pkg::REG_WINDOW_LENGTH);

   always_comb begin
      window_length_in = window_length_ff;
      rate_scale_in    = rate_scale_ff;
      if (win_write) begin
         window_length_in = csr_data[crta_pkg::WLEN_W-1:0];
      end
      if (csr_write && csr_index == crta_pkg::REG_RATE_SCALE) begin
         rate_scale_in = csr_data[crta_pkg::SCALE_W-1:0];
      end
   end

   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = LW'(1);
      end else if (int'(window_length_ff) > WINDOW_MAX) begin
         len_eff = WMAX_L;
      end else begin
         len_eff = LW'(window_length_ff);
      end
   end

   // per-class state
   logic [crta_pkg::COUNT_W-1:0] last_count_ff [NUM_CLASSES];
   logic [crta_pkg::SUM_W-1:0]   sum_ff        [NUM_CLASSES];
   logic [PW-1:0]                pos_ff        [NUM_CLASSES];

   // sequencer
   crta_pkg::sweep_ctl_type ctl;
   logic [AW-1:0]           sweep_index;
   logic [AW-1:0]           acc_index;
   logic [CW-1:0]           sw_cls, acc_cls;
   logic [PW-1:0]           sw_k, acc_k, sw_slot;
   logic                    acc_first, acc_incl;

   // input register
   logic                         s1_valid_ff, s1_valid_in;
   logic [crta_pkg::CLASS_W-1:0] s1_echo_ff;
   logic [CW-1:0]                s1_cls_ff;
   logic [crta_pkg::COUNT_W-1:0] s1_count_ff;
   logic                         s1_byp_ff;
   logic [crta_pkg::DELTA_W-1:0] s1_byp_data_ff;

   logic                         s1_ready, s1_leave, s2_ready, req_accept;
   logic [CW-1:0]                req_cls;
   logic [PW-1:0]                req_pos, req_slot, s1_pos;
   logic                         same_cls, req_byp;
   logic [crta_pkg::DELTA_W-1:0] s1_delta, s1_old, ring_rd_data, ring_wr_data;
   logic [crta_pkg::SUM_W-1:0]   s1_sum;
   logic                         ring_wr_en, ring_rd_en;
   logic [AW-1:0]                ring_wr_addr, ring_rd_addr;

   crta_sweep #(
      .NUM_CLASSES(NUM_CLASSES),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .win_write  (win_write),
      .ctl        (ctl),
      .sweep_index(sweep_index),
      .acc_index  (acc_index)
   );

   assign sw_cls    = sweep_index[AW-1:PW];
   assign sw_k      = sweep_index[PW-1:0];
   assign sw_slot   = slot_back(pos_ff[sw_cls], {1'b0, sw_k} + LW'(1));
   assign acc_cls   = acc_index[AW-1:PW];
   assign acc_k     = acc_index[PW-1:0];
   assign acc_first = (acc_k == '0);
   assign acc_incl  = ({1'b0, acc_k} < len_eff);

   // handshake
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign s1_leave    = s1_valid_ff && s2_ready;
   assign req_ready   = !ctl.busy && s1_ready;
   assign req_accept  = req_valid && req_ready;
   assign s1_valid_in = s1_ready ? req_accept : s1_valid_ff;

   // oldest-delta read, forwarded past the item still in the input register
   assign req_cls  = class_fold(req_traffic_class);
   assign s1_pos   = pos_ff[s1_cls_ff];
   assign same_cls = s1_valid_ff && (s1_cls_ff == req_cls);
   assign req_pos  = same_cls ? pos_inc(s1_pos) : pos_ff[req_cls];
   assign req_slot = slot_back(req_pos, len_eff);
   assign req_byp  = same_cls && (req_slot == s1_pos);

   assign s1_delta = s1_count_ff - last_count_ff[s1_cls_ff];
   assign s1_old   = s1_byp_ff ? s1_byp_data_ff : ring_rd_data;
   assign s1_sum   = sum_ff[s1_cls_ff] + crta_pkg::SUM_W'(s1_delta)
                     - crta_pkg::SUM_W'(s1_old);

   assign ring_wr_en   = ctl.clear || s1_leave;
   assign ring_wr_addr = ctl.clear ? sweep_index : {s1_cls_ff, s1_pos};
   assign ring_wr_data = ctl.clear ? '0 : s1_delta;
   assign ring_rd_en   = req_accept || ctl.resum_rd;
   assign ring_rd_addr = ctl.resum_rd ? {sw_cls, sw_slot} : {req_cls, req_slot};

   crta_ring #(
      .NUM_CLASSES(NUM_CLASSES),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_wr_en),
      .wr_addr(ring_wr_addr),
      .wr_data(ring_wr_data),
      .rd_en  (ring_rd_en),
      .rd_addr(ring_rd_addr),
      .rd_data(ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= crta_pkg::WINDOW_LENGTH_RST;
         rate_scale_ff    <= crta_pkg::RATE_SCALE_RST;
         s1_valid_ff      <= 1'b0;
      end else begin
         window_length_ff <= window_length_in;
         rate_scale_ff    <= rate_scale_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_echo_ff     <= req_traffic_class;
         s1_cls_ff      <= req_cls;
         s1_count_ff    <= req_cumulative_count;
         s1_byp_ff      <= req_byp;
         s1_byp_data_ff <= s1_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            last_count_ff[c] <= '0;
            sum_ff[c]        <= '0;
            pos_ff[c]        <= '0;
         end
      end else if (ctl.acc_valid) begin
         sum_ff[acc_cls] <= (acc_first ? '0 : sum_ff[acc_cls])
                            + (acc_incl ? crta_pkg::SUM_W'(ring_rd_data) : '0);
      end else if (s1_leave) begin
         last_count_ff[s1_cls_ff] <= s1_count_ff;
         sum_ff[s1_cls_ff]        <= s1_sum;
         pos_ff[s1_cls_ff]        <= pos_inc(s1_pos);
      end
   end

   crta_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_ready        (s2_ready),
      .in_echo         (s1_echo_ff),
      .in_delta        (s1_delta),
      .in_sum          (s1_sum),
      .rate_scale      (rate_scale_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_class_echo  (rsp_class_echo),
      .rsp_new_delta   (rsp_new_delta),
      .rsp_average_rate(rsp_average_rate)
   );

   a_clear_no_item_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && s1_leave))
      else $error("item write to ring during clearing pass");

   a_bypass_len_one: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_byp) |-> (len_eff == LW'(1)))
      else $error("ring read bypass with window longer than one");

endmodule
